// File: rtl/touch_pointer_id_assigner_defines.svh
// Assertion macros for the touch pointer id assigner.
`ifndef TOUCH_POINTER_ID_ASSIGNER_DEFINES_SVH
`define TOUCH_POINTER_ID_ASSIGNER_DEFINES_SVH
`ifndef SYNTH
`define TPIA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpia: same-cycle check failed");
`define TPIA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpia: next-cycle check failed");
`else
`define TPIA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TPIA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/tpia_pkg.sv
// Types, constants and helpers shared by the touch pointer id assigner.
`default_nettype none
package tpia_pkg;

   localparam int unsigned MAX_PTRS_DEF = 16;
   localparam int unsigned ID_COUNT_DEF = 32;

   // Id index width follows the pointer_id field.
   localparam int unsigned ID_W   = 5;
   localparam int unsigned TID_W  = 16;
   localparam int unsigned PIDX_W = 4;
   localparam int unsigned PCNT_W = 5;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned RSP_USER_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;

   // Tool codes
   localparam logic [2:0] TOOL_UNKNOWN = 3'd0;
   localparam logic [2:0] TOOL_FINGER  = 3'd1;
   localparam logic [2:0] TOOL_STYLUS  = 3'd2;
   localparam logic [2:0] TOOL_MOUSE   = 3'd3;
   localparam logic [2:0] TOOL_ERASER  = 3'd4;
   localparam logic [2:0] TOOL_PALM    = 3'd5;

   // Result kinds
   localparam logic [1:0] RK_POINTER = 2'd0;
   localparam logic [1:0] RK_CANCEL  = 2'd1;
   localparam logic [1:0] RK_SUMMARY = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIM_STYLUS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_OK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_STYLUS   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Search word that walks down the cell row, one cell per cycle.
   typedef struct packed {
      logic             valid;
      logic [TID_W-1:0] tid;
      logic             hit;
      logic [ID_W-1:0]  hit_id;
      logic             free;
      logic [ID_W-1:0]  free_id;
   } srch_tok_type;

   // Update broadcast to every cell when an item retires.
   typedef struct packed {
      logic             commit;
      logic             clear_next;
      logic             mark;
      logic             alloc;
      logic [ID_W-1:0]  id;
      logic [TID_W-1:0] tid;
   } upd_type;

   // Codes six and seven count as unknown.
   function automatic logic [2:0] norm_tool(input logic [2:0] t);
      return (t > TOOL_PALM) ? TOOL_UNKNOWN : t;
   endfunction

endpackage
`default_nettype wire

// File: rtl/touch_pointer_id_assigner.sv
// Top level of the touch pointer id assigner: control, result register and cell row.
//
// Usage:
//  - req channel takes one word per in-use contact slot (req_tuser = 0) and one
//    end-of-frame word (req_tuser = 1). rsp channel returns zero or one word per
//    request: a pointer, an id cancel, or the frame summary.
//  - csr channel writes simulate_stylus (0), pressure_axis_valid (1) and
//    source_has_stylus (2); it is always ready. Write only while idle.
//  - Contacts that need an id lookup walk a row of ID_COUNT cells, one cell per
//    cycle; the outcome is captured as it leaves the last cell, then resolved and
//    the result word registered. End-of-frame words and contacts that skip the
//    lookup (frame full, negative id, ids already lost) go straight to resolve.
//  - The cell row walk sets the rate: at most one search word per item.
//  - One item is in flight at a time; req_tready is high in the idle state.
//  - A finished result sits in the output register. A stalled rsp side holds
//    that word and lets the next item be accepted and searched; the item then
//    waits for the register before it retires, if it has a word to send.
//  - Reset clears the id maps, frame counters and configuration; ids_ok
//    comes up set. No clearing pass is needed.
`default_nettype none
`include "touch_pointer_id_assigner_defines.svh"
module touch_pointer_id_assigner #(
   parameter int unsigned MAX_PTRS = tpia_pkg::MAX_PTRS_DEF,
   parameter int unsigned ID_COUNT = tpia_pkg::ID_COUNT_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // req_tdata: tracking_id[16:0], slot_tool[19:17], button_tool[22:20],
   //            button_hovering[23], pos_x[39:24], pos_y[55:40], pressure[71:56]
   input  wire  [tpia_pkg::REQ_DATA_W-1:0]       req_tdata,
   // req_tuser: kind[0]
   input  wire  [tpia_pkg::REQ_USER_W-1:0]       req_tuser,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata: pointer_index[3:0], pointer_id[8:4], id_valid[9], tool_type[12:10],
   //            hovering[13], out_x[29:14], out_y[45:30], out_pressure[61:46],
   //            pointer_count[66:62], ids_lost[67], stylus_added[68], zero[71:69]
   output logic [tpia_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: result_kind[1:0]
   output logic [tpia_pkg::RSP_USER_W-1:0]       rsp_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [tpia_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire                                   csr_data
);
   import tpia_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PTRS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PTRS);

   // Control state
   state_type        state_ff, state_in;
   logic             launch_ff, launch_in;
   logic [CNT_W-1:0] frame_count_ff;
   logic             frame_full_ff, ids_ok_ff, stylus_seen_ff;
   logic             sim_stylus_ff, pres_valid_ff, src_stylus_ff;

   // Held item
   logic             itm_kind_ff, itm_neg_ff, itm_bhov_ff;
   logic [TID_W-1:0] itm_tid_ff;
   logic [2:0]       itm_stool_ff, itm_btool_ff;
   logic [15:0]      itm_x_ff, itm_y_ff, itm_p_ff;

   // Search outcome
   logic             srch_hit_ff, srch_free_ff;
   logic [ID_W-1:0]  srch_hit_id_ff, srch_free_id_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic             accept, need_walk, fire;
   logic [2:0]       req_stool;
   upd_type          upd;
   srch_tok_type     tok_row [ID_COUNT+1];

   // Outcome of the held item
   logic             o_res, o_commit, o_full_set, o_count_inc, o_ok_clear;
   logic             o_alloc, o_mark, o_seen_set, o_idv, o_hov, o_added;
   logic [1:0]       o_kind;
   logic [ID_W-1:0]  o_id;
   logic [2:0]       o_tool;
   logic             is_palm, can_id;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign req_stool = norm_tool(req_tdata[19:17]);

   // Walk the row only where the lookup result is used.
   assign need_walk = !req_tuser[0] && !frame_full_ff && ids_ok_ff && !req_tdata[16] &&
                      ((req_stool == TOOL_PALM) || (frame_count_ff < CNT_MAX));

   // Resolve the held item into a result and state effects.
   assign is_palm = (itm_stool_ff == TOOL_PALM);
   assign can_id  = ids_ok_ff && !itm_neg_ff;

   always_comb begin
      o_res = 1'b0; o_commit = 1'b0; o_full_set = 1'b0; o_count_inc = 1'b0;
      o_ok_clear = 1'b0; o_alloc = 1'b0; o_mark = 1'b0; o_seen_set = 1'b0;
      o_idv = 1'b0; o_hov = 1'b0; o_added = 1'b0;
      o_kind = RK_POINTER; o_id = '0; o_tool = TOOL_UNKNOWN;
      priority if (itm_kind_ff) begin
         o_res    = 1'b1;
         o_kind   = RK_SUMMARY;
         o_commit = 1'b1;
      end else if (frame_full_ff) begin
         o_res = 1'b0;
      end else if (is_palm) begin
         // cancel only an id that is active
         if (can_id && srch_hit_ff) begin
            o_res  = 1'b1;
            o_kind = RK_CANCEL;
            o_id   = srch_hit_id_ff;
         end
      end else if (frame_count_ff >= CNT_MAX) begin
         o_full_set = 1'b1;
      end else begin
         o_res       = 1'b1;
         o_kind      = RK_POINTER;
         o_count_inc = 1'b1;
         o_tool      = itm_stool_ff;
         if (itm_stool_ff == TOOL_UNKNOWN) begin
            o_tool = (itm_btool_ff == TOOL_UNKNOWN) ? TOOL_FINGER : itm_btool_ff;
         end else if (itm_stool_ff == TOOL_STYLUS && !stylus_seen_ff) begin
            o_seen_set = 1'b1;
            o_added    = !src_stylus_ff;
         end
         if (sim_stylus_ff && o_tool == TOOL_FINGER) o_tool = TOOL_STYLUS;
         o_hov = (itm_btool_ff != TOOL_MOUSE) &&
                 (itm_bhov_ff || (pres_valid_ff && itm_p_ff == 16'd0));
         if (ids_ok_ff) begin
            priority if (can_id && srch_hit_ff) begin
               o_mark = 1'b1;
               o_id   = srch_hit_id_ff;
               o_idv  = 1'b1;
            end else if (can_id && srch_free_ff) begin
               o_alloc = 1'b1;
               o_mark  = 1'b1;
               o_id    = srch_free_id_ff;
               o_idv   = 1'b1;
            end else begin
               o_ok_clear = 1'b1;
            end
         end
      end
   end

   // Next state and handshake
   always_comb begin
      state_in   = state_ff;
      launch_in  = 1'b0;
      req_tready = 1'b0;
      fire       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in  = need_walk ? ST_WALK : ST_EMIT;
               launch_in = need_walk;
            end
         end
         ST_WALK: begin
            if (tok_row[ID_COUNT].valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output register only when there is a word to send
            fire = !o_res || !rsp_valid_ff || rsp_tready;
            if (fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
      end
   end

   // Frame state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         frame_full_ff  <= 1'b0;
         ids_ok_ff      <= 1'b1;
         stylus_seen_ff <= 1'b0;
         sim_stylus_ff  <= 1'b0;
         pres_valid_ff  <= 1'b0;
         src_stylus_ff  <= 1'b0;
      end else begin
         if (fire) begin
            if (o_commit) begin
               frame_count_ff <= '0;
               frame_full_ff  <= 1'b0;
               ids_ok_ff      <= 1'b1;
            end else begin
               if (o_count_inc) frame_count_ff <= frame_count_ff + CNT_W'(1);
               if (o_full_set) frame_full_ff <= 1'b1;
               if (o_ok_clear) ids_ok_ff <= 1'b0;
            end
            if (o_seen_set) stylus_seen_ff <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SIM_STYLUS:  sim_stylus_ff <= csr_data;
               CSR_PRESSURE_OK: pres_valid_ff <= csr_data;
               CSR_SRC_STYLUS:  src_stylus_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         itm_kind_ff  <= req_tuser[0];
         itm_neg_ff   <= req_tdata[16];
         itm_tid_ff   <= req_tdata[15:0];
         itm_stool_ff <= req_stool;
         itm_btool_ff <= norm_tool(req_tdata[22:20]);
         itm_bhov_ff  <= req_tdata[23];
         itm_x_ff     <= req_tdata[39:24];
         itm_y_ff     <= req_tdata[55:40];
         itm_p_ff     <= req_tdata[71:56];
      end
   end

   // Capture the search word as it leaves the last cell
   always_ff @(posedge clock) begin
      if (tok_row[ID_COUNT].valid) begin
         srch_hit_ff     <= tok_row[ID_COUNT].hit;
         srch_hit_id_ff  <= tok_row[ID_COUNT].hit_id;
         srch_free_ff    <= tok_row[ID_COUNT].free;
         srch_free_id_ff <= tok_row[ID_COUNT].free_id;
      end
   end

   // Launch a fresh search word into the first cell
   always_comb begin
      tok_row[0]         = '0;
      tok_row[0].valid   = launch_ff;
      tok_row[0].tid     = itm_tid_ff;
   end

   // Broadcast updates only when the item retires
   always_comb begin
      upd            = '0;
      upd.commit     = fire && o_commit;
      upd.clear_next = fire && o_ok_clear;
      upd.mark       = fire && o_mark;
      upd.alloc      = fire && o_alloc;
      upd.id         = o_id;
      upd.tid        = itm_tid_ff;
   end

   for (genvar gi = 0; gi < ID_COUNT; gi++) begin : g_cell
      tpia_cell #(
         .IDX (gi)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .upd_i (upd),
         .tok_i (tok_row[gi]),
         .tok_o (tok_row[gi+1])
      );
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (fire && o_res) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = o_kind;
         if (o_kind == RK_SUMMARY) begin
            rsp_data_in = {3'b000, 1'b0, !ids_ok_ff, PCNT_W'(frame_count_ff), 62'd0};
         end else if (o_kind == RK_CANCEL) begin
            rsp_data_in = {63'd0, o_id, 4'd0};
         end else begin
            rsp_data_in = {3'b000, o_added, 1'b0, 5'd0, itm_p_ff, itm_y_ff, itm_x_ff,
                           o_hov, o_tool, o_idv, o_id, PIDX_W'(frame_count_ff)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   `TPIA_ASSERT_IMP(a_exit_in_walk, clock, reset, tok_row[ID_COUNT].valid, state_ff == ST_WALK)
   `TPIA_ASSERT_IMP(a_launch_in_walk, clock, reset, launch_ff, state_ff == ST_WALK)
   `TPIA_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, frame_count_ff <= CNT_MAX)
   `TPIA_ASSERT_IMP(a_alloc_needs_ok, clock, reset, upd.alloc, ids_ok_ff && srch_free_ff)
   `TPIA_ASSERT_NXT(a_summary_clears, clock, reset, upd.commit, ids_ok_ff && !frame_full_ff)

endmodule
`default_nettype wire

// File: rtl/tpia_cell.sv
// One id slot: active and next bits, tracking id, and one stage of the search row.
`default_nettype none
module tpia_cell #(
   parameter int unsigned IDX = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  tpia_pkg::upd_type      upd_i,
   input  tpia_pkg::srch_tok_type tok_i,
   output tpia_pkg::srch_tok_type tok_o
);
   import tpia_pkg::*;

   localparam logic [ID_W-1:0] MY_ID = ID_W'(IDX);

   logic             active_ff, active_in;
   logic             next_ff, next_in;
   logic [TID_W-1:0] trk_ff;
   srch_tok_type     tok_ff, tok_in;
   logic             sel;

   assign sel = (upd_i.id == MY_ID);

   always_comb begin
      active_in = active_ff;
      next_in   = next_ff;
      if (upd_i.commit) begin
         active_in = next_ff;
         next_in   = 1'b0;
      end else begin
         if (upd_i.alloc && sel) active_in = 1'b1;
         if (upd_i.clear_next) next_in = 1'b0;
         else if (upd_i.mark && sel) next_in = 1'b1;
      end
   end

   // Take the first match and the first free slot, lowest id first.
   always_comb begin
      tok_in = tok_i;
      if (tok_i.valid) begin
         if (!tok_i.hit && active_ff && (trk_ff == tok_i.tid)) begin
            tok_in.hit    = 1'b1;
            tok_in.hit_id = MY_ID;
         end
         if (!tok_i.free && !active_ff) begin
            tok_in.free    = 1'b1;
            tok_in.free_id = MY_ID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         next_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         active_ff    <= active_in;
         next_ff      <= next_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.tid     <= tok_in.tid;
      tok_ff.hit     <= tok_in.hit;
      tok_ff.hit_id  <= tok_in.hit_id;
      tok_ff.free    <= tok_in.free;
      tok_ff.free_id <= tok_in.free_id;
   end

   always_ff @(posedge clock) begin
      if (upd_i.alloc && sel) trk_ff <= upd_i.tid;
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire
